### sv/hans_pkg.sv
// Shared types, constants and helpers of the HEVC Annex B NAL splitter.
`timescale 1ns / 1ps

package hans_pkg;

    // Results one input byte can cause: three held zeros plus the byte itself
    localparam int MAX_PUSH     = 4;
    localparam int PUSH_CNT_W   = 3;
    localparam int DEF_Q_DEPTH  = 8;

    // Start code pieces and parameter-set NAL types
    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [7:0] SC_ONE_BYTE  = 8'h01;
    localparam logic [7:0] HDR_TYPE_MASK = 8'h7E;
    localparam logic [5:0] TYPE_VPS     = 6'd32;
    localparam logic [5:0] TYPE_SPS     = 6'd33;
    localparam logic [5:0] TYPE_PPS     = 6'd34;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_VPS   = 2'd1;
    localparam logic [1:0] KIND_SPS   = 2'd2;
    localparam logic [1:0] KIND_PPS   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       nal_first;
        logic [5:0] nal_type;
        logic [1:0] param_set_kind;
        logic       last_of_packet;
    } t_out_item;

    // Group of items handed from the parser to the result queue in one cycle
    typedef struct packed {
        logic [PUSH_CNT_W-1:0]        num;
        t_out_item [MAX_PUSH-1:0]     ent;
    } t_push;

    function automatic logic [1:0] kind_of(input logic [5:0] nal_type);
        logic [1:0] kind;
        kind = KIND_OTHER;
        if (nal_type == TYPE_VPS) kind = KIND_VPS;
        if (nal_type == TYPE_SPS) kind = KIND_SPS;
        if (nal_type == TYPE_PPS) kind = KIND_PPS;
        return kind;
    endfunction

endpackage

### sv/hans_parser.sv
// Input register and start code parser: turns one byte into up to four NAL items.
`timescale 1ns / 1ps

module hans_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hans_pkg::t_in_item  i_item,
    input  logic                i_space,
    output hans_pkg::t_push     o_push
);
    import hans_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic [1:0] r_held_count;
    logic       r_inside_nal;
    logic       r_expect_header;
    logic [5:0] r_current_type;

    logic       take;
    logic       zero_case;
    logic       start_case;
    logic       other_case;
    logic       packet_end;
    logic [7:0] data_byte;
    logic [1:0] held_after;
    logic [PUSH_CNT_W-1:0] count_main;
    logic [PUSH_CNT_W-1:0] count_all;
    logic [PUSH_CNT_W-1:0] count_out;
    logic [7:0] hdr_byte;
    logic [5:0] type_out;
    t_push      push;

    logic [1:0] n_held_count;
    logic       n_inside_nal;
    logic       n_expect_header;
    logic [5:0] n_current_type;

    // Take the held item once the queue has room for a full group
    assign take    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || take;

    // Hold the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    // Classify the byte against the held zero run
    assign data_byte  = r_in.data_byte;
    assign packet_end = r_in.packet_end;
    assign zero_case  = (data_byte == SC_ZERO_BYTE);
    assign start_case = (data_byte == SC_ONE_BYTE) && r_held_count[1];
    assign other_case = !zero_case && !start_case;

    always_comb begin
        if (zero_case) begin
            count_main = (r_held_count == 2'd3) ? PUSH_CNT_W'(1) : PUSH_CNT_W'(0);
            held_after = (r_held_count == 2'd3) ? 2'd3 : r_held_count + 2'd1;
        end else if (start_case) begin
            count_main = '0;
            held_after = 2'd0;
        end else begin
            count_main = PUSH_CNT_W'(r_held_count) + PUSH_CNT_W'(1);
            held_after = 2'd0;
        end
        // Flush the held zeros after the byte at packet end
        count_all = count_main + (packet_end ? PUSH_CNT_W'(held_after) : '0);
        count_out = r_inside_nal ? count_all : '0;
    end

    // Emitted bytes are zeros except the non-zero byte after the released run
    assign hdr_byte = (other_case && r_held_count == 2'd0) ? data_byte : SC_ZERO_BYTE;
    assign type_out = (r_expect_header && count_out != '0)
                    ? 6'((hdr_byte & HDR_TYPE_MASK) >> 1) : r_current_type;

    // Build the item group
    always_comb begin
        push.num = take ? count_out : '0;
        for (int i = 0; i < MAX_PUSH; i++) begin
            push.ent[i].nal_byte = (other_case && r_held_count == 2'(i))
                                 ? data_byte : SC_ZERO_BYTE;
            push.ent[i].nal_first      = (i == 0) && r_expect_header;
            push.ent[i].nal_type       = type_out;
            push.ent[i].param_set_kind = kind_of(type_out);
            push.ent[i].last_of_packet = packet_end
                                       && (count_out == PUSH_CNT_W'(i + 1));
        end
    end

    assign o_push = push;

    // Advance the parser state
    always_comb begin
        n_held_count    = packet_end ? 2'd0 : held_after;
        n_current_type  = type_out;
        n_inside_nal    = r_inside_nal;
        n_expect_header = r_expect_header;
        if (start_case) begin
            n_inside_nal    = 1'b1;
            n_expect_header = 1'b1;
        end else if (count_out != '0) begin
            n_expect_header = 1'b0;
        end
        if (packet_end) begin
            n_inside_nal    = 1'b0;
            n_expect_header = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count    <= 2'd0;
            r_inside_nal    <= 1'b0;
            r_expect_header <= 1'b0;
            r_current_type  <= 6'd0;
        end else if (take) begin
            r_held_count    <= n_held_count;
            r_inside_nal    <= n_inside_nal;
            r_expect_header <= n_expect_header;
            r_current_type  <= n_current_type;
        end
    end

    // A packet end leaves no held zeros and no open NAL
    a_pend_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && packet_end |=> r_held_count == 2'd0 && !r_inside_nal)
        else $error("packet end did not clear parser state");

    // Nothing is emitted outside a NAL
    a_no_emit_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside_nal |-> push.num == '0)
        else $error("item emitted outside a NAL");

endmodule

### sv/hans_queue.sv
// Result queue: takes a group of up to four items a cycle, hands out one a cycle while i_ready is high.
`timescale 1ns / 1ps

module hans_queue #(
    parameter int DEPTH = hans_pkg::DEF_Q_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hans_pkg::t_push     i_push,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output hans_pkg::t_out_item o_item
);
    import hans_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out_item       r_mem [DEPTH];
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];
    assign pop     = o_valid && i_ready;
    assign o_space = (r_count <= CW'(DEPTH - MAX_PUSH));

    // Write the group at the tail
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (PUSH_CNT_W'(i) < i_push.num) begin
                r_mem[r_tail + AW'(i)] <= i_push.ent[i];
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + AW'(i_push.num);
            r_head  <= r_head + AW'(pop);
            r_count <= r_count + CW'(i_push.num) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != '0 |-> o_space)
        else $error("group pushed without room");

endmodule

### sv/hevc_annexb_nal_splitter.sv
// Top level of the HEVC Annex B NAL splitter.
//
// Input channel: one stream byte per item with a packet-end flag
// (i_valid / o_ready / i_item). Output channel: one NAL byte per item with
// its header mark, NAL type, parameter-set class and last-of-packet mark
// (o_valid / i_ready / o_item).
// Start codes (00 00 01 or 00 00 00 01) are stripped, bytes before the
// first start code of a packet are dropped, and up to three trailing zeros
// are held until a later byte or the packet end decides their fate.
// Results pass the input register and the queue. Throughput: one input
// item per cycle while each byte yields at most one result and the receiver
// is ready; a byte that releases held zeros yields up to four results, which
// leave the output queue at one per cycle. The input register is emptied
// into the queue only when it has room for four items, so o_ready drops
// while the register is full and the queue holds more than DEPTH - 4 items.
// Reset clears the input register, the parser state and the queue.
// A stalled receiver fills the queue and then stalls the input side;
// no item is lost or repeated.
`timescale 1ns / 1ps

module hevc_annexb_nal_splitter #(
    parameter int Q_DEPTH = hans_pkg::DEF_Q_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hans_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output hans_pkg::t_out_item o_item
);
    import hans_pkg::*;

    t_push push;
    logic  space;

    hans_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_space (space),
        .o_push  (push)
    );

    hans_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
